FILE: hdl/prwm_pkg.sv
package prwm_pkg;

  localparam int unsigned WindowDepthDef = 1024;
  localparam int unsigned TimeBitsDef    = 32;

  localparam int unsigned CfgW       = 32;
  localparam int unsigned FieldTimeW = 32;
  localparam int unsigned CountW     = 11;

  typedef enum logic {
    StIdle,
    StCheck
  } state_e;

endpackage

FILE: hdl/prwm_ram.sv
module prwm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/peak_rate_window_monitor.sv
// flow: an accepted beat moves the fsm from StIdle to StCheck, which ages out entries one per cycle
//   through the single read port of the timestamp ram, then registers the result once the output
//   is free; no new beat is taken until the fsm is back in StIdle
// reset: asynchronous, clears pointers, counts, best window, overflow flag and
//   window_length; the timestamp ram is not cleared and needs no clearing pass
module peak_rate_window_monitor #(
  parameter int unsigned WindowDepth = prwm_pkg::WindowDepthDef,
  parameter int unsigned TimeBits    = prwm_pkg::TimeBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [prwm_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [prwm_pkg::FieldTimeW-1:0] event_time_i,
  input  logic                            new_batch_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [prwm_pkg::CountW-1:0]     best_count_o,
  output logic [prwm_pkg::FieldTimeW-1:0] best_start_o,
  output logic [prwm_pkg::FieldTimeW-1:0] best_end_o,
  output logic [prwm_pkg::CountW-1:0]     window_count_o,
  output logic                            overflowed_o
);

  import prwm_pkg::*;

  localparam int unsigned PtrW = $clog2(WindowDepth);
  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam int unsigned CmpW = (TimeBits > FieldTimeW) ? TimeBits : FieldTimeW;
  localparam logic [PtrW-1:0] LastSlot  = PtrW'(WindowDepth - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(WindowDepth);
  localparam logic [CntW-1:0] OneCount  = CntW'(1);

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == LastSlot) ? '0 : p + PtrW'(1);
  endfunction

  state_e state_q, state_d;

  logic [CfgW-1:0]     wlen_q;
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     best_cnt_q, best_cnt_d;
  logic [TimeBits-1:0] best_first_q, best_first_d, best_last_q, best_last_d;
  logic                ovf_q, ovf_d;
  logic [TimeBits-1:0] now_q, now_d;
  logic                fwd_q, fwd_d;

  logic                  out_valid_q, out_valid_d;
  logic [CountW-1:0]     out_best_cnt_q, out_best_cnt_d;
  logic [FieldTimeW-1:0] out_start_q, out_start_d, out_end_q, out_end_d;
  logic [CountW-1:0]     out_wcnt_q, out_wcnt_d;
  logic                  out_ovf_q, out_ovf_d;

  logic                ram_we, ram_re;
  logic [PtrW-1:0]     ram_waddr, ram_raddr;
  logic [TimeBits-1:0] ram_wdata, ram_rdata;

  logic                accept, out_free, pop, upd, finish, full;
  logic [TimeBits-1:0] now_in, diff, oldest;
  logic [PtrW-1:0]     head_b, tail_b, head_acc;
  logic [CntW-1:0]     count_b;

  prwm_ram #(
    .Width(TimeBits),
    .Depth(WindowDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign now_in     = TimeBits'(CmpW'(event_time_i));

  // a push into an empty window reads the entry being written
  assign oldest = fwd_q ? now_q : ram_rdata;

  // entry aging and best window test against the oldest held timestamp
  assign diff = now_q - oldest;
  assign pop  = (count_q > OneCount) && (now_q > oldest)
                && (CmpW'(diff) > CmpW'(wlen_q));
  assign upd  = (count_q > OneCount) && (count_q > best_cnt_q) && (now_q > oldest);

  assign head_b  = new_batch_i ? '0 : head_q;
  assign tail_b  = new_batch_i ? '0 : tail_q;
  assign count_b = new_batch_i ? '0 : count_q;
  assign full    = (count_b == FullCount);
  assign head_acc = full ? next_slot(head_b) : head_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (!pop && out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    best_cnt_d   = best_cnt_q;
    best_first_d = best_first_q;
    best_last_d  = best_last_q;
    ovf_d        = ovf_q;
    now_d        = now_q;
    fwd_d        = fwd_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = now_in;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    finish       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          head_d    = head_acc;
          tail_d    = next_slot(tail_b);
          count_d   = full ? count_b : count_b + OneCount;
          ovf_d     = (ovf_q && !new_batch_i) || full;
          now_d     = now_in;
          fwd_d     = (count_b == '0);
          ram_we    = 1'b1;
          ram_waddr = tail_b;
          ram_re    = 1'b1;
          ram_raddr = head_acc;
          if (new_batch_i) begin
            best_cnt_d   = '0;
            best_first_d = '0;
            best_last_d  = '0;
          end
        end
      end
      StCheck: begin
        if (pop) begin
          head_d    = next_slot(head_q);
          count_d   = count_q - OneCount;
          fwd_d     = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = next_slot(head_q);
        end else if (out_free) begin
          finish = 1'b1;
          if (upd) begin
            best_cnt_d   = count_q;
            best_first_d = oldest;
            best_last_d  = now_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d    = finish || (out_valid_q && !out_ready_i);
    out_best_cnt_d = out_best_cnt_q;
    out_start_d    = out_start_q;
    out_end_d      = out_end_q;
    out_wcnt_d     = out_wcnt_q;
    out_ovf_d      = out_ovf_q;
    if (finish) begin
      out_best_cnt_d = CountW'(best_cnt_d);
      out_start_d    = FieldTimeW'(CmpW'(best_first_d));
      out_end_d      = FieldTimeW'(CmpW'(best_last_d));
      out_wcnt_d     = CountW'(count_q);
      out_ovf_d      = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      wlen_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      best_cnt_q   <= '0;
      best_first_q <= '0;
      best_last_q  <= '0;
      ovf_q        <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      best_cnt_q   <= best_cnt_d;
      best_first_q <= best_first_d;
      best_last_q  <= best_last_d;
      ovf_q        <= ovf_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q          <= now_d;
    out_best_cnt_q <= out_best_cnt_d;
    out_start_q    <= out_start_d;
    out_end_q      <= out_end_d;
    out_wcnt_q     <= out_wcnt_d;
    out_ovf_q      <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign best_count_o   = out_best_cnt_q;
  assign best_start_o   = out_start_q;
  assign best_end_o     = out_end_q;
  assign window_count_o = out_wcnt_q;
  assign overflowed_o   = out_ovf_q;

endmodule

FILE: hdl/prwm_checker.sv
module prwm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [prwm_pkg::CountW-1:0]     best_count_o,
  input logic [prwm_pkg::FieldTimeW-1:0] best_start_o,
  input logic [prwm_pkg::FieldTimeW-1:0] best_end_o,
  input logic [prwm_pkg::CountW-1:0]     window_count_o,
  input logic                            overflowed_o
);

  import prwm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_count_o)
      && $stable(best_start_o) && $stable(best_end_o)
      && $stable(window_count_o) && $stable(overflowed_o))
    else $error("result beat changed while stalled");

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a beat");

  // the newest event is always held
  a_window_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_count_o != '0)
    else $error("empty window reported");

  // a single event spans no time, so it never becomes the best window
  a_best_not_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_count_o != CountW'(1))
    else $error("best window of one event");

endmodule

bind peak_rate_window_monitor prwm_checker u_prwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .best_count_o  (best_count_o),
  .best_start_o  (best_start_o),
  .best_end_o    (best_end_o),
  .window_count_o(window_count_o),
  .overflowed_o  (overflowed_o)
);

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prwm_pkg::*;

  localparam int unsigned Depth      = WindowDepthDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned MaxReports = 10;

  typedef logic [FieldTimeW-1:0] stamp_t;
  typedef logic [CountW-1:0]     count_t;

  typedef struct packed {
    count_t best_cnt;
    stamp_t first_t;
    stamp_t last_t;
    count_t held;
    logic   ovf;
  } peak_rec_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic           in_valid_i;
  logic           in_ready_o;
  stamp_t         event_time_i;
  logic           new_batch_i;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  count_t         best_count_o;
  stamp_t         best_start_o;
  stamp_t         best_end_o;
  count_t         window_count_o;
  logic           overflowed_o;

  peak_rate_window_monitor u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .event_time_i   (event_time_i),
    .new_batch_i    (new_batch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_count_o   (best_count_o),
    .best_start_o   (best_start_o),
    .best_end_o     (best_end_o),
    .window_count_o (window_count_o),
    .overflowed_o   (overflowed_o)
  );

  // window tracker state
  stamp_t                   slot_time [Depth];
  logic [$clog2(Depth)-1:0] oldest_ptr;
  logic [$clog2(Depth)-1:0] next_ptr;
  count_t                   held_events;
  count_t                   peak_events;
  stamp_t                   peak_first;
  stamp_t                   peak_last;
  logic                     dropped_seen;
  logic [CfgW-1:0]          window_len;

  peak_rec_t   pending_peaks [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        tx_idle_en;
  logic        rx_idle_en;
  int unsigned hold_req;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("peak_rate_window_monitor: mismatch");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap      <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && out_ready_i && $urandom_range(0, 3) == 0) begin
      rx_gap      <= idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    peak_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_peaks.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < MaxReports)
          $display("unexpected result beat: best=%0d start=%0h end=%0h held=%0d ovf=%0b",
                   best_count_o, best_start_o, best_end_o, window_count_o, overflowed_o);
      end else begin
        want = pending_peaks.pop_front();
        if (want.best_cnt !== best_count_o || want.first_t !== best_start_o ||
            want.last_t !== best_end_o || want.held !== window_count_o ||
            want.ovf !== overflowed_o) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < MaxReports)
            $display({"result differs: expected best=%0d start=%0h end=%0h held=%0d ",
                      "ovf=%0b, got best=%0d start=%0h end=%0h held=%0d ovf=%0b"},
                     want.best_cnt, want.first_t, want.last_t, want.held, want.ovf,
                     best_count_o, best_start_o, best_end_o, window_count_o,
                     overflowed_o);
        end
      end
    end
  end

  task automatic clear_window();
    oldest_ptr   = '0;
    next_ptr     = '0;
    held_events  = '0;
    peak_events  = '0;
    peak_first   = '0;
    peak_last    = '0;
    dropped_seen = 1'b0;
  endtask

  task automatic track_event(input stamp_t now, input logic nb);
    stamp_t    oldest;
    peak_rec_t rec;
    if (nb) clear_window();
    if (held_events >= Depth) begin
      oldest_ptr   = oldest_ptr + 1;
      held_events  = held_events - 1;
      dropped_seen = 1'b1;
    end
    slot_time[next_ptr] = now;
    next_ptr    = next_ptr + 1;
    held_events = held_events + 1;
    oldest = slot_time[oldest_ptr];
    while (held_events > 1 && now > oldest && (now - oldest) > window_len) begin
      oldest_ptr  = oldest_ptr + 1;
      held_events = held_events - 1;
      oldest      = slot_time[oldest_ptr];
    end
    if (held_events > peak_events && now > oldest) begin
      peak_events = held_events;
      peak_first  = oldest;
      peak_last   = now;
    end
    rec.best_cnt = peak_events;
    rec.first_t  = peak_first;
    rec.last_t   = peak_last;
    rec.held     = held_events;
    rec.ovf      = dropped_seen;
    pending_peaks.push_back(rec);
  endtask

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_event(input stamp_t t, input logic nb);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    event_time_i <= t;
    new_batch_i  <= nb;
    do @(posedge clk_i); while (!in_ready_o);
    track_event(t, nb);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [CfgW-1:0] len);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_len = len;
  endtask

  task automatic test_directed();
    // reset window of zero: equal times span nothing
    send_event(32'd0, 1'b1);
    send_event(32'd0, 1'b0);
    send_event(32'd5, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b0);
    send_event(32'd3, 1'b0);
    set_window(32'd10);
    send_event(32'd100, 1'b1);
    send_event(32'd105, 1'b0);
    send_event(32'd110, 1'b0);
    send_event(32'd111, 1'b0);
    send_event(32'd112, 1'b0);
    send_event(32'd113, 1'b0);
    send_event(32'd50, 1'b0);
    send_event(32'd114, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b0);
    set_window(32'hFFFF_FFFF);
    send_event(32'd0, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b0);
    send_event(32'h8000_0000, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b1);
    send_event(32'h5555_AAAA, 1'b0);
    send_event(32'hAAAA_5555, 1'b1);
  endtask

  task automatic test_overflow();
    set_window(32'hFFFF_FFFF);
    send_event(32'd1000, 1'b1);
    for (int i = 1; i < Depth + 8; i++) send_event(32'd1000 + i, 1'b0);
    send_event(32'd7, 1'b1);
  endtask

  task automatic test_backpressure();
    stamp_t t;
    set_window(32'd20);
    t = $urandom;
    hold_req <= hold_req + 1;
    send_event(t, 1'b1);
    for (int i = 0; i < 60; i++) begin
      t = t + $urandom_range(0, 4);
      send_event(t, 1'b0);
    end
    wait_drained();
    for (int i = 0; i < 30; i++) begin
      t = t + $urandom_range(0, 4);
      send_event(t, 1'b0);
    end
  endtask

  task automatic random_phase(input logic [CfgW-1:0] len, input int unsigned n,
                              input logic idle);
    stamp_t      cur;
    stamp_t      t;
    logic        nb;
    int unsigned r;
    set_window(len);
    tx_idle_en = idle;
    rx_idle_en = idle;
    cur = $urandom;
    send_event(cur, 1'b1);
    for (int unsigned i = 1; i < n; i++) begin
      r  = $urandom_range(0, 99);
      nb = 1'b0;
      if (r < 2) begin
        cur = $urandom;
        t   = cur;
        nb  = 1'b1;
      end else if (r < 6) begin
        t = $urandom;
      end else if (r < 9) begin
        t = cur - $urandom_range(1, 20);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) cur = cur + $urandom_range(0, 3);
        else if (r < 98) cur = cur + $urandom_range(0, 40);
        else cur = cur + $urandom;
        t = cur;
      end
      send_event(t, nb);
    end
  endtask

  task automatic test_random();
    random_phase($urandom_range(0, 64), 180, 1'b1);
    random_phase(32'd0, 180, 1'b1);
    random_phase(32'hFFFF_FFFF, 180, 1'b0);
    random_phase($urandom, 180, 1'b1);
    random_phase($urandom_range(1, 1000), 180, 1'b1);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    event_time_i = '0;
    new_batch_i  = 1'b0;
    hold_req     = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    window_len   = '0;
    clear_window();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_overflow();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("peak_rate_window_monitor: match");
    end else begin
      $display("peak_rate_window_monitor: mismatch");
    end
    $finish;
  end

endmodule
